>>> rtl/core/lbcd_pkg.sv
// Package: shared types and constants for the blink-code number display.
`default_nettype none

package lbcd_pkg;

	localparam int unsigned ThresholdWidth = 8;
	localparam int unsigned TicksWidth     = 16;
	localparam int unsigned CfgDataWidth   = 16;
	localparam int unsigned TimerWidth     = 5;
	localparam int unsigned TensWidth      = 5;
	localparam int unsigned UnitsWidth     = 4;

	localparam logic [7:0] ThresholdReset = 8'd34;
	localparam logic [15:0] TicksReset    = 16'd1;

	// Register indexes of the configuration port
	typedef enum logic {
		CFG_THRESHOLD_VALUE = 1'b0,
		CFG_TICKS_PER_UNIT  = 1'b1
	} cfg_index_t;

	// Operation codes of an input transaction
	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} op_t;

	typedef struct packed {
		logic              operation;
		logic signed [7:0] reading;
		logic              show_threshold;
	} in_t;

	typedef struct packed {
		logic led;
		logic busy_res;
		logic done_res;
	} out_t;

	// Configuration values seen by the sequencer
	typedef struct packed {
		logic [ThresholdWidth-1:0] threshold_value;
		logic [TicksWidth-1:0]     ticks_per_unit;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/lbcd_seq.sv
// Blink sequencer: phase, unit timer, prescaler and digit counters.
`default_nettype none

module lbcd_seq #(
	parameter int unsigned QUIET_GAP_UNITS = 20
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               step,
	input  lbcd_pkg::in_t     item,
	input  lbcd_pkg::cfg_t    cfg,
	output lbcd_pkg::out_t    result
);

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_MINUS_ON  = 4'd1,
		PH_MINUS_OFF = 4'd2,
		PH_TENS_ON   = 4'd3,
		PH_TENS_OFF  = 4'd4,
		PH_TENS_GAP  = 4'd5,
		PH_UNITS_ON  = 4'd6,
		PH_UNITS_OFF = 4'd7,
		PH_TAIL      = 4'd8,
		PH_QUIET     = 4'd9
	} phase_t;

	localparam int unsigned TW = lbcd_pkg::TimerWidth;
	localparam logic [TW-1:0] QuietLen = TW'(QUIET_GAP_UNITS);

	phase_t                              phase_q, phase_d, adv_phase;
	logic [TW-1:0]                       timer_q, timer_d, timer_dec;
	logic [lbcd_pkg::TicksWidth-1:0]     presc_q, presc_d;
	logic [lbcd_pkg::TensWidth-1:0]      tens_q, tens_d, tens_dec;
	logic [lbcd_pkg::UnitsWidth-1:0]     units_q, units_d, units_dec;
	logic                                busy, done;
	logic [lbcd_pkg::TicksWidth-1:0]     tpu;
	logic [lbcd_pkg::TicksWidth:0]       presc_inc;
	logic [7:0]                          mag, rd_bits;
	logic                                minus;
	logic [15:0]                         recip;
	logic [4:0]                          q_tens;
	logic [7:0]                          q_units_w;
	logic [3:0]                          q_units;

	function automatic logic [TW-1:0] phase_len(input phase_t p);
		logic [TW-1:0] len;
		unique case (p)
			PH_MINUS_ON:  len = TW'(2);
			PH_MINUS_OFF: len = TW'(4);
			PH_TENS_GAP:  len = TW'(4);
			PH_TAIL:      len = TW'(2);
			PH_QUIET:     len = QuietLen;
			PH_IDLE:      len = '0;
			default:      len = TW'(1);
		endcase
		return len;
	endfunction

	assign busy = (phase_q >= PH_MINUS_ON) && (phase_q <= PH_QUIET);

	// Split the magnitude into tens and units: q/10 as (q*205)>>11, exact for 8 bits
	assign rd_bits   = item.reading;
	assign minus     = !item.show_threshold && rd_bits[7];
	assign mag       = item.show_threshold ? cfg.threshold_value
	                   : (minus ? 8'(~rd_bits + 8'd1) : rd_bits);
	assign recip     = 16'(mag) * 16'd205;
	assign q_tens    = recip[15:11];
	assign q_units_w = mag - 8'(q_tens) * 8'd10;
	assign q_units   = q_units_w[3:0];

	assign tpu       = (cfg.ticks_per_unit == '0) ? lbcd_pkg::TicksWidth'(1)
	                   : cfg.ticks_per_unit;
	assign presc_inc = {1'b0, presc_q} + 1'b1;
	assign timer_dec = timer_q - 1'b1;
	assign tens_dec  = tens_q - 1'b1;
	assign units_dec = units_q - 1'b1;

	// Next phase at the end of the current one
	always_comb begin
		adv_phase = PH_IDLE;
		unique case (phase_q)
			PH_MINUS_ON:  adv_phase = PH_MINUS_OFF;
			PH_MINUS_OFF: adv_phase = (tens_q != '0) ? PH_TENS_ON : PH_UNITS_ON;
			PH_TENS_ON:   adv_phase = PH_TENS_OFF;
			PH_TENS_OFF:  adv_phase = (tens_dec != '0) ? PH_TENS_ON : PH_TENS_GAP;
			PH_TENS_GAP:  adv_phase = PH_UNITS_ON;
			PH_UNITS_ON:  adv_phase = PH_UNITS_OFF;
			PH_UNITS_OFF: adv_phase = (units_dec != '0) ? PH_UNITS_ON : PH_TAIL;
			PH_TAIL:      adv_phase = PH_QUIET;
			default:      adv_phase = PH_IDLE;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		presc_d = presc_q;
		tens_d  = tens_q;
		units_d = units_q;
		done    = 1'b0;
		// Drop an unused phase code back to idle
		if (!busy) begin
			phase_d = PH_IDLE;
			timer_d = '0;
		end
		if (item.operation == lbcd_pkg::OP_START) begin
			if (!busy) begin
				tens_d  = q_tens;
				units_d = (q_units == '0) ? lbcd_pkg::UnitsWidth'(10) : q_units;
				presc_d = '0;
				if (minus) begin
					phase_d = PH_MINUS_ON;
				end else if (q_tens != '0) begin
					phase_d = PH_TENS_ON;
				end else begin
					phase_d = PH_UNITS_ON;
				end
				timer_d = phase_len(phase_d);
			end
		end else if (busy) begin
			if (presc_inc >= {1'b0, tpu}) begin
				presc_d = '0;
				timer_d = timer_dec;
				if (timer_dec == '0) begin
					phase_d = adv_phase;
					timer_d = phase_len(adv_phase);
					done    = (phase_q == PH_QUIET);
					if (phase_q == PH_TENS_OFF) begin
						tens_d = tens_dec;
					end
					if (phase_q == PH_UNITS_OFF) begin
						units_d = units_dec;
					end
				end
			end else begin
				presc_d = presc_inc[lbcd_pkg::TicksWidth-1:0];
			end
		end
	end

	assign result.led      = (phase_d == PH_MINUS_ON) || (phase_d == PH_TENS_ON)
	                         || (phase_d == PH_UNITS_ON);
	assign result.busy_res = (phase_d != PH_IDLE);
	assign result.done_res = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			presc_q <= '0;
			tens_q  <= '0;
			units_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			presc_q <= presc_d;
			tens_q  <= tens_d;
			units_q <= units_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/lbcd_out_q.sv
// Two-entry result queue between the sequencer and the output channel.
`default_nettype none

module lbcd_out_q (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  lbcd_pkg::out_t  push_data,
	output logic            full,
	output logic            out_valid,
	input  wire             out_stall,
	output lbcd_pkg::out_t  out_data
);

	lbcd_pkg::out_t slot_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;
	logic           pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = slot_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/led_blink_code_number_display.sv
// Top level: blink-code number display with configuration registers.
//
// Shows a signed reading or the threshold register on one LED as blink code.
// Every input transaction (a tick or a start) yields exactly one result
// transaction carrying the LED level, busy and done after that step. One
// transaction is taken per clock: the sequencer updates its state at the
// accepting edge and the result goes into a two-entry output queue, so input
// stalls only while both queue entries hold results not yet taken.
// Configuration writes take effect at the next edge.
`default_nettype none

module led_blink_code_number_display #(
	parameter int unsigned QUIET_GAP_UNITS = 20
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  lbcd_pkg::in_t                        in_data,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output lbcd_pkg::out_t                       out_data,
	input  wire                                  cfg_write_en,
	input  wire                                  cfg_index,
	input  wire [lbcd_pkg::CfgDataWidth-1:0]     cfg_data
);

	lbcd_pkg::cfg_t cfg_q;
	lbcd_pkg::out_t step_result;
	logic           accept;
	logic           q_full;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_value <= lbcd_pkg::ThresholdReset;
			cfg_q.ticks_per_unit  <= lbcd_pkg::TicksReset;
		end else if (cfg_write_en) begin
			unique case (lbcd_pkg::cfg_index_t'(cfg_index))
				lbcd_pkg::CFG_THRESHOLD_VALUE:
					cfg_q.threshold_value <= cfg_data[lbcd_pkg::ThresholdWidth-1:0];
				lbcd_pkg::CFG_TICKS_PER_UNIT:
					cfg_q.ticks_per_unit <= cfg_data[lbcd_pkg::TicksWidth-1:0];
				default: begin
				end
			endcase
		end
	end

	lbcd_seq #(
		.QUIET_GAP_UNITS(QUIET_GAP_UNITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.item   (in_data),
		.cfg    (cfg_q),
		.result (step_result)
	);

	lbcd_out_q u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (step_result),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

>>> bench/led_blink_code_number_display_tb.sv
`timescale 1ns / 100ps
// Testbench: drives tick/start transactions, predicts blink-code results and checks them.

module led_blink_code_number_display_tb;

	localparam int QuietGapUnits = 20;
	localparam int WatchdogLimit = 5000;
	localparam int HoldCycles    = 300;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_MINUS_ON  = 4'd1,
		PH_MINUS_OFF = 4'd2,
		PH_TENS_ON   = 4'd3,
		PH_TENS_OFF  = 4'd4,
		PH_TENS_GAP  = 4'd5,
		PH_UNITS_ON  = 4'd6,
		PH_UNITS_OFF = 4'd7,
		PH_TAIL      = 4'd8,
		PH_QUIET     = 4'd9
	} blink_phase_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	lbcd_pkg::in_t        in_data;
	logic                 out_valid;
	logic                 out_stall;
	lbcd_pkg::out_t       out_data;
	logic                 cfg_write_en;
	lbcd_pkg::cfg_index_t cfg_index;
	logic [15:0]          cfg_data;

	led_blink_code_number_display i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Shadow of the sequencer and its registers
	blink_phase_t seq_phase;
	logic [4:0]   unit_count;
	logic [15:0]  tick_count;
	logic [4:0]   tens_count;
	logic [3:0]   ones_count;
	logic [7:0]   cur_threshold;
	logic [15:0]  cur_tick_div;

	lbcd_pkg::in_t  item_q[$];
	lbcd_pkg::out_t blink_q[$];
	int             pushed_items;
	int             sent_items;
	int             checked_results;
	int             done_pulses;
	int             fail_count;
	int             idle_mode;
	int             quiet_cycles;
	int             hold_left;
	bit             hold_done;
	lbcd_pkg::out_t want;

	function automatic void enter_phase(blink_phase_t p);
		case (p)
			PH_MINUS_ON:  unit_count = 5'd2;
			PH_MINUS_OFF: unit_count = 5'd4;
			PH_TENS_GAP:  unit_count = 5'd4;
			PH_TAIL:      unit_count = 5'd2;
			PH_QUIET:     unit_count = 5'(QuietGapUnits);
			PH_IDLE:      unit_count = 5'd0;
			default:      unit_count = 5'd1;
		endcase
		seq_phase = p;
	endfunction

	// Move on at the end of a phase; return 1 when the quiet gap ends.
	function automatic bit next_phase();
		case (seq_phase)
			PH_MINUS_ON:  enter_phase(PH_MINUS_OFF);
			PH_MINUS_OFF: enter_phase(tens_count != 0 ? PH_TENS_ON : PH_UNITS_ON);
			PH_TENS_ON:   enter_phase(PH_TENS_OFF);
			PH_TENS_OFF: begin
				tens_count = tens_count - 5'd1;
				enter_phase(tens_count != 0 ? PH_TENS_ON : PH_TENS_GAP);
			end
			PH_TENS_GAP:  enter_phase(PH_UNITS_ON);
			PH_UNITS_ON:  enter_phase(PH_UNITS_OFF);
			PH_UNITS_OFF: begin
				ones_count = ones_count - 4'd1;
				enter_phase(ones_count != 0 ? PH_UNITS_ON : PH_TAIL);
			end
			PH_TAIL:      enter_phase(PH_QUIET);
			PH_QUIET: begin
				enter_phase(PH_IDLE);
				return 1'b1;
			end
			default:      enter_phase(PH_IDLE);
		endcase
		return 1'b0;
	endfunction

	function automatic lbcd_pkg::out_t blink_step(lbcd_pkg::in_t item);
		lbcd_pkg::out_t res;
		bit             was_busy;
		bit             pulse;
		bit             neg;
		logic [7:0]     mag;
		logic [15:0]    div;
		logic [16:0]    next_count;
		was_busy = (seq_phase != PH_IDLE);
		pulse = 1'b0;
		if (item.operation == lbcd_pkg::OP_START) begin
			if (!was_busy) begin
				neg = 1'b0;
				if (item.show_threshold) begin
					mag = cur_threshold;
				end else if (item.reading[7]) begin
					neg = 1'b1;
					mag = ~item.reading + 8'd1;
				end else begin
					mag = item.reading;
				end
				tens_count = 5'(mag / 8'd10);
				ones_count = 4'(mag % 8'd10);
				if (ones_count == 0)
					ones_count = 4'd10;
				tick_count = '0;
				if (neg)
					enter_phase(PH_MINUS_ON);
				else
					enter_phase(tens_count != 0 ? PH_TENS_ON : PH_UNITS_ON);
			end
		end else if (was_busy) begin
			div = (cur_tick_div == 0) ? 16'd1 : cur_tick_div;
			next_count = {1'b0, tick_count} + 17'd1;
			if (next_count >= {1'b0, div}) begin
				tick_count = '0;
				unit_count = unit_count - 5'd1;
				if (unit_count == 0)
					pulse = next_phase();
			end else begin
				tick_count = next_count[15:0];
			end
		end
		res.led = (seq_phase == PH_MINUS_ON || seq_phase == PH_TENS_ON ||
			seq_phase == PH_UNITS_ON);
		res.busy_res = (seq_phase != PH_IDLE);
		res.done_res = pulse;
		return res;
	endfunction

	function automatic bit coin(int pct);
		return $urandom_range(99) < pct;
	endfunction

	task automatic compare_bit(string name, logic exp_bit, logic got_bit);
		if (got_bit !== exp_bit) begin
			$display("%0t: %s mismatch, expected %b, actual %b", $time, name, exp_bit, got_bit);
			fail_count++;
		end
	endtask

	task automatic push_item(lbcd_pkg::op_t op, logic [7:0] rd, logic sel);
		lbcd_pkg::in_t item;
		item.operation = op;
		item.reading = rd;
		item.show_threshold = sel;
		item_q.push_back(item);
		pushed_items++;
	endtask

	// One start followed by ticks; a stray start now and then lands while busy.
	task automatic push_show(logic sel, logic [7:0] rd, int ticks);
		push_item(lbcd_pkg::OP_START, rd, sel);
		repeat (ticks) begin
			if ($urandom_range(39) == 0)
				push_item(lbcd_pkg::OP_START, 8'($urandom), 1'($urandom));
			else
				push_item(lbcd_pkg::OP_TICK, 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic push_random_shows(int n, int div);
		int target;
		logic [7:0] rd;
		target = pushed_items + n;
		while (pushed_items < target) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 4))
					push_item(lbcd_pkg::op_t'($urandom_range(1)), 8'($urandom),
						1'($urandom));
			end
			case ($urandom_range(7))
				0:       rd = 8'h80;
				1:       rd = 8'h7f;
				2:       rd = 8'h00;
				3:       rd = 8'hff;
				default: rd = 8'($urandom);
			endcase
			push_show($urandom_range(3) == 0, rd, div * $urandom_range(25, 95));
		end
	endtask

	// Hold until every transaction is through.
	task automatic settle();
		while (item_q.size() != 0 || blink_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(lbcd_pkg::cfg_index_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == lbcd_pkg::CFG_THRESHOLD_VALUE)
			cur_threshold = val[7:0];
		else
			cur_tick_div = val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: offer the oldest pending item, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				blink_q.push_back(blink_step(in_data));
				void'(item_q.pop_front());
				sent_items++;
			end
			if (!in_valid || !in_stall) begin
				if (item_q.size() != 0 &&
					!coin(idle_mode == 0 ? 28 : idle_mode == 1 ? 50 : 0)) begin
					in_valid <= 1'b1;
					in_data <= item_q[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transaction against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (blink_q.size() == 0) begin
					$display("%0t: unexpected result, actual %b", $time, out_data);
					fail_count++;
				end else begin
					want = blink_q.pop_front();
					compare_bit("led", want.led, out_data.led);
					compare_bit("busy_res", want.busy_res, out_data.busy_res);
					compare_bit("done_res", want.done_res, out_data.done_res);
					checked_results++;
					if (out_data.done_res === 1'b1)
						done_pulses++;
				end
			end
			if (idle_mode == 2 && !hold_done) begin
				hold_left = HoldCycles;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= coin(idle_mode == 0 ? 50 : idle_mode == 1 ? 28 : 0);
			end
		end
	end

	// Watchdog: cycles in which neither channel moves a transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
				$display("FAIL led_blink_code_number_display");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = lbcd_pkg::CFG_THRESHOLD_VALUE;
		cfg_data = '0;
		seq_phase = PH_IDLE;
		unit_count = '0;
		tick_count = '0;
		tens_count = '0;
		ones_count = '0;
		cur_threshold = lbcd_pkg::ThresholdReset;
		cur_tick_div = lbcd_pkg::TicksReset;
		pushed_items = 0;
		sent_items = 0;
		checked_results = 0;
		done_pulses = 0;
		fail_count = 0;
		idle_mode = 0;
		quiet_cycles = 0;
		hold_left = 0;
		hold_done = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: ticks while idle, threshold start, start while busy, early ticks
		push_item(lbcd_pkg::OP_TICK, 8'h7f, 1'b1);
		push_item(lbcd_pkg::OP_TICK, 8'h80, 1'b0);
		push_item(lbcd_pkg::OP_START, 8'h80, 1'b1);
		push_item(lbcd_pkg::OP_START, 8'hff, 1'b0);
		repeat (19) push_item(lbcd_pkg::OP_TICK, 8'h00, 1'b0);
		push_item(lbcd_pkg::OP_START, 8'h7f, 1'b1);
		push_random_shows(250, 1);
		settle();

		write_reg(lbcd_pkg::CFG_THRESHOLD_VALUE, 16'd0);
		write_reg(lbcd_pkg::CFG_TICKS_PER_UNIT, 16'd0);
		push_show(1'b1, 8'h00, 50);
		push_random_shows(250, 1);
		settle();

		write_reg(lbcd_pkg::CFG_THRESHOLD_VALUE, 16'd255);
		write_reg(lbcd_pkg::CFG_TICKS_PER_UNIT, 16'd2);
		idle_mode = 1;
		push_show(1'b1, 8'h80, 2 * 95);
		push_random_shows(210, 2);
		settle();

		write_reg(lbcd_pkg::CFG_THRESHOLD_VALUE, 16'($urandom_range(255)));
		write_reg(lbcd_pkg::CFG_TICKS_PER_UNIT, 16'd3);
		push_random_shows(300, 3);
		settle();

		// Slowest prescaler: the sequence only gets started here
		write_reg(lbcd_pkg::CFG_TICKS_PER_UNIT, 16'hffff);
		push_show(1'b0, 8'h80, 200);
		idle_mode = 2;
		settle();

		write_reg(lbcd_pkg::CFG_THRESHOLD_VALUE, 16'($urandom_range(255)));
		write_reg(lbcd_pkg::CFG_TICKS_PER_UNIT, 16'd1);
		push_random_shows(250, 1);

		settle();
		repeat (10) @(posedge clk);
		if (blink_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, blink_q.size());
			fail_count++;
		end
		$display("Sent %0d tick/start transactions, checked %0d results, %0d done pulses,",
			sent_items, checked_results, done_pulses);
		$display("over six register settings with idling on both sides and one long output hold.");
		if (fail_count == 0)
			$display("PASS led_blink_code_number_display");
		else
			$display("FAIL led_blink_code_number_display");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/lbcd_pkg.sv
rtl/core/lbcd_seq.sv
rtl/core/lbcd_out_q.sv
rtl/core/led_blink_code_number_display.sv
bench/led_blink_code_number_display_tb.sv
